FILE: rtl/lsms_pkg.sv
// Shared types, widths and codes for the lattice site magnitude statistics block.
package lsms_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_SITES_DEF        = 4096;
   localparam int SAMPLES_PER_SITE_DEF = 8;

   // Field and state widths
   localparam int SUM_W        = 36;
   localparam int SQ_W         = 50;
   localparam int SAMPLE_CNT_W = 20;
   localparam int SET_CNT_W    = 16;
   localparam int SITE_W       = 12;
   localparam int MAG_SQ_W     = 32;
   localparam int OUT_W        = 16;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   // Iterative arithmetic unit widths and step counts
   localparam int OPND_W     = 50;
   localparam int MEAN_W     = 36;
   localparam int DIVR_W     = 20;
   localparam int REM_W      = 28;
   localparam int ROOT_W     = 25;
   localparam int PROD_W     = 64;
   localparam int STEP_W     = 6;
   localparam int DIV_STEPS  = 50;
   localparam int SQRT_STEPS = 25;
   localparam int MUL_STEPS  = 36;

   localparam logic [SET_CNT_W-1:0] SET_COUNT_MAX = '1;

   // Opcodes
   localparam logic [1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_CLEAR      = 2'd2;

   // Register indexes (byte address bits [4:2])
   localparam logic [2:0] REG_SIZE_DIM0 = 3'd0;
   localparam logic [2:0] REG_SIZE_DIM1 = 3'd1;
   localparam logic [2:0] REG_SIZE_DIM2 = 3'd2;
   localparam logic [2:0] REG_SIZE_DIM3 = 3'd3;
   localparam logic [2:0] REG_PAD_DIM1  = 3'd4;
   localparam logic [2:0] REG_PAD_DIM2  = 3'd5;
   localparam logic [2:0] REG_PAD_DIM3  = 3'd6;

   typedef struct packed {
      logic [1:0]        opcode;
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic [SITE_W-1:0] site_index;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] mean;
      logic [OUT_W-1:0] sigma;
      logic [OUT_W-1:0] mean_error;
      logic             has_data;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  sq_sum;
   } site_word_type;

   typedef enum logic [1:0] {
      MATH_DIV,
      MATH_SQRT,
      MATH_MUL
   } math_op_type;

   typedef struct packed {
      logic              start;
      math_op_type       op;
      logic [OPND_W-1:0] a;
      logic [MEAN_W-1:0] b;
   } math_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] result;
   } math_sts_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_MAG,
      ST_RD_FETCH,
      ST_RD_MEAN,
      ST_RD_MSQ,
      ST_RD_SQR,
      ST_RD_SIG,
      ST_RD_VDIV,
      ST_RD_ERR,
      ST_RD_DONE
   } state_type;

endpackage

FILE: rtl/lattice_site_magnitude_statistics_top.sv
// Top level: lattice stream walker, control sequencer, register port and site store.
//
// Use of the block:
// - req channel (valid/ready) carries one beat per operation: accumulate a Q4.12
//   complex sample, read the statistics of one site, or clear everything.
// - rsp channel (valid/ready) carries one beat per read: mean, sigma, error of
//   the mean (Q4.12) and a has_data flag. Accumulate and clear give no beat.
// - csr port is APB-style, always ready; extents and padding at 4*index.
// - One operation is in flight at a time; req_ready is high only when idle.
// - Accumulate: for a sample at a real site the next req beat waits on the
//   25-step square root of the shared iterative unit and the store
//   read-modify-write; a padding or dropped sample leaves the block idle.
// - Read: once a sample set is complete, the shared unit runs two 50-step divides,
//   a 36-step multiply, two 25-step roots and a divide by the set count before rsp
//   valid; the next req beat can be taken in the cycle in which rsp valid rises.
// - Clear: one store entry per cycle, MaxSites entries (4096 by default).
// - After reset the same clearing pass runs over all MaxSites entries before the
//   first req beat is taken; csr writes are taken throughout.
// - A finished read result sits in the rsp register; while the receiver
//   stalls, accumulates still proceed, and a further read waits for it.
module lattice_site_magnitude_statistics_top
   import lsms_pkg::*;
#(
   parameter int MaxSites       = MAX_SITES_DEF,
   parameter int SamplesPerSite = SAMPLES_PER_SITE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AddrW = (MaxSites > 1) ? $clog2(MaxSites) : 1;
   localparam int ClrW  = $clog2(MaxSites + 1);
   localparam int LaneW = (SamplesPerSite > 1) ? $clog2(SamplesPerSite) : 1;
   localparam logic [LaneW-1:0] LaneLast = LaneW'(SamplesPerSite - 1);

   function automatic logic [3:0] clamp_ext(input logic [3:0] s);
      logic [3:0] r;
      if (s == 4'd0) begin
         r = 4'd1;
      end else if (s > 4'd8) begin
         r = 4'd8;
      end else begin
         r = s;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [3:0] size_ff [4];
   logic [2:0] pad_ff  [3];
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) size_ff[i] <= 4'd4;
         for (int i = 0; i < 3; i++) pad_ff[i] <= 3'd0;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_SIZE_DIM0: size_ff[0] <= csr_pwdata[3:0];
            REG_SIZE_DIM1: size_ff[1] <= csr_pwdata[3:0];
            REG_SIZE_DIM2: size_ff[2] <= csr_pwdata[3:0];
            REG_SIZE_DIM3: size_ff[3] <= csr_pwdata[3:0];
            REG_PAD_DIM1:  pad_ff[0]  <= csr_pwdata[2:0];
            REG_PAD_DIM2:  pad_ff[1]  <= csr_pwdata[2:0];
            REG_PAD_DIM3:  pad_ff[2]  <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_SIZE_DIM0: csr_prdata = CSR_DATA_W'(size_ff[0]);
         REG_SIZE_DIM1: csr_prdata = CSR_DATA_W'(size_ff[1]);
         REG_SIZE_DIM2: csr_prdata = CSR_DATA_W'(size_ff[2]);
         REG_SIZE_DIM3: csr_prdata = CSR_DATA_W'(size_ff[3]);
         REG_PAD_DIM1:  csr_prdata = CSR_DATA_W'(pad_ff[0]);
         REG_PAD_DIM2:  csr_prdata = CSR_DATA_W'(pad_ff[1]);
         REG_PAD_DIM3:  csr_prdata = CSR_DATA_W'(pad_ff[2]);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   logic [2:0]  pos0_ff, pos0_in;
   logic [3:0]  pos1_ff, pos1_in, pos2_ff, pos2_in, pos3_ff, pos3_in;
   logic [LaneW-1:0] lane_ff, lane_in;
   logic [SITE_W-1:0] site_ff, site_in;
   logic [SAMPLE_CNT_W-1:0] sample_count_ff, sample_count_in;
   logic [SET_CNT_W-1:0]    set_count_ff, set_count_in;
   logic [ClrW-1:0]         clr_ff, clr_in;

   logic [AddrW-1:0]    addr_ff, addr_in;
   logic [MAG_SQ_W-1:0] sq_ff, sq_in;
   logic                zero_ff, zero_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic [SQ_W-1:0]     msq_ff, msq_in;
   logic [SQ_W-1:0]     var_ff, var_in;
   logic [OUT_W-1:0]    sig_ff, sig_in;
   logic [OUT_W-1:0]    err_ff, err_in;
   logic                has_ff, has_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------- stream walk
   // Next lattice position after one accumulate beat.
   logic [3:0] s0, s1, s2, s3;
   logic [4:0] e1, e2, e3;
   logic [4:0] p1n, p2n, p3n;
   logic [3:0] p0n;
   logic       real_pos, in_store;
   logic [2:0] adv_pos0;
   logic [3:0] adv_pos1, adv_pos2, adv_pos3;
   logic [LaneW-1:0] adv_lane;
   logic [SITE_W-1:0] adv_site;
   logic              adv_set;

   always_comb begin
      s0 = clamp_ext(size_ff[0]);
      s1 = clamp_ext(size_ff[1]);
      s2 = clamp_ext(size_ff[2]);
      s3 = clamp_ext(size_ff[3]);
      e1 = 5'(s1) + 5'(pad_ff[0]);
      e2 = 5'(s2) + 5'(pad_ff[1]);
      e3 = 5'(s3) + 5'(pad_ff[2]);
      p0n = 4'(pos0_ff) + 4'd1;
      p1n = 5'(pos1_ff) + 5'd1;
      p2n = 5'(pos2_ff) + 5'd1;
      p3n = 5'(pos3_ff) + 5'd1;
      real_pos = (4'(pos0_ff) < s0) && (pos1_ff < s1) && (pos2_ff < s2) && (pos3_ff < s3);
      in_store = 17'(site_ff) < 17'(MaxSites);

      adv_pos0 = pos0_ff;
      adv_pos1 = pos1_ff;
      adv_pos2 = pos2_ff;
      adv_pos3 = pos3_ff;
      adv_site = site_ff;
      adv_set  = 1'b0;
      adv_lane = lane_ff + 1'b1;
      if (lane_ff == LaneLast) begin
         adv_lane = '0;
         if (real_pos) adv_site = site_ff + 1'b1;
         if (p3n < e3) begin
            adv_pos3 = p3n[3:0];
         end else begin
            adv_pos3 = '0;
            if (p2n < e2) begin
               adv_pos2 = p2n[3:0];
            end else begin
               adv_pos2 = '0;
               if (p1n < e1) begin
                  adv_pos1 = p1n[3:0];
               end else begin
                  adv_pos1 = '0;
                  if (p0n < s0) begin
                     adv_pos0 = p0n[2:0];
                  end else begin
                     // whole padded set done
                     adv_pos0 = '0;
                     adv_site = '0;
                     adv_set  = 1'b1;
                  end
               end
            end
         end
      end
   end

   // squared magnitude of the incoming sample, exact
   logic signed [31:0]  re_sq, im_sq;
   logic [MAG_SQ_W-1:0] sample_sq;
   assign re_sq     = req_data.sample_re * req_data.sample_re;
   assign im_sq     = req_data.sample_im * req_data.sample_im;
   assign sample_sq = MAG_SQ_W'(re_sq) + MAG_SQ_W'(im_sq);

   // ---------------------------------------------------------------- store and unit
   logic          mem_we, mem_re;
   logic [AddrW-1:0] mem_waddr, mem_raddr;
   site_word_type mem_wdata, mem_rdata;
   math_cmd_type  math_cmd;
   math_sts_type  math_sts;

   lsms_store #(
      .Depth (MaxSites),
      .AddrW (AddrW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   lsms_math u_math (
      .clock (clock),
      .reset (reset),
      .cmd   (math_cmd),
      .sts   (math_sts)
   );

   // ---------------------------------------------------------------- sequencer
   logic             accept;
   logic [SQ_W-1:0]  sum_op, sqs_op;
   logic [PROD_W-1:0] msq_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign sum_op    = zero_ff ? '0 : SQ_W'(mem_rdata.sum);
   assign sqs_op    = zero_ff ? '0 : mem_rdata.sq_sum;
   assign msq_ext   = PROD_W'(msq_ff);

   always_comb begin
      state_in        = state_ff;
      pos0_in         = pos0_ff;
      pos1_in         = pos1_ff;
      pos2_in         = pos2_ff;
      pos3_in         = pos3_ff;
      lane_in         = lane_ff;
      site_in         = site_ff;
      sample_count_in = sample_count_ff;
      set_count_in    = set_count_ff;
      clr_in          = clr_ff;
      addr_in         = addr_ff;
      sq_in           = sq_ff;
      zero_in         = zero_ff;
      mean_in         = mean_ff;
      msq_in          = msq_ff;
      var_in          = var_ff;
      sig_in          = sig_ff;
      err_in          = err_ff;
      has_in          = has_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;

      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = AddrW'(site_ff);
      math_cmd  = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff[AddrW-1:0];
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ClrW'(MaxSites - 1)) state_in = ST_IDLE;
         end

         ST_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  OP_ACCUMULATE: begin
                     if (set_count_ff != SET_COUNT_MAX) begin
                        pos0_in = adv_pos0;
                        pos1_in = adv_pos1;
                        pos2_in = adv_pos2;
                        pos3_in = adv_pos3;
                        lane_in = adv_lane;
                        site_in = adv_site;
                        if (adv_set) begin
                           sample_count_in = SAMPLE_CNT_W'(sample_count_ff + SamplesPerSite);
                           set_count_in    = set_count_ff + 1'b1;
                        end
                        if (real_pos && in_store) begin
                           mem_re     = 1'b1;
                           addr_in    = AddrW'(site_ff);
                           sq_in      = sample_sq;
                           math_cmd.start = 1'b1;
                           math_cmd.op    = MATH_SQRT;
                           math_cmd.a     = OPND_W'(sample_sq);
                           state_in   = ST_ACC_MAG;
                        end
                     end
                  end
                  OP_READ: begin
                     zero_in   = !(17'(req_data.site_index) < 17'(MaxSites));
                     mem_re    = 1'b1;
                     mem_raddr = AddrW'(req_data.site_index);
                     state_in  = ST_RD_FETCH;
                  end
                  OP_CLEAR: begin
                     pos0_in         = '0;
                     pos1_in         = '0;
                     pos2_in         = '0;
                     pos3_in         = '0;
                     lane_in         = '0;
                     site_in         = '0;
                     sample_count_in = '0;
                     set_count_in    = '0;
                     clr_in          = '0;
                     state_in        = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end

         ST_ACC_MAG: begin
            if (math_sts.done) begin
               mem_we           = 1'b1;
               mem_wdata.sum    = mem_rdata.sum + SUM_W'(math_sts.result[OUT_W-1:0]);
               mem_wdata.sq_sum = mem_rdata.sq_sum + SQ_W'(sq_ff);
               state_in         = ST_IDLE;
            end
         end

         ST_RD_FETCH: begin
            if (sample_count_ff != '0 && set_count_ff != '0) begin
               math_cmd.start = 1'b1;
               math_cmd.op    = MATH_DIV;
               math_cmd.a     = sum_op;
               math_cmd.b     = MEAN_W'(sample_count_ff);
               state_in       = ST_RD_MEAN;
            end else begin
               mean_in  = '0;
               sig_in   = '0;
               err_in   = '0;
               has_in   = 1'b0;
               state_in = ST_RD_DONE;
            end
         end

         ST_RD_MEAN: begin
            if (math_sts.done) begin
               mean_in        = math_sts.result[MEAN_W-1:0];
               math_cmd.start = 1'b1;
               math_cmd.op    = MATH_DIV;
               math_cmd.a     = sqs_op;
               math_cmd.b     = MEAN_W'(sample_count_ff);
               state_in       = ST_RD_MSQ;
            end
         end

         ST_RD_MSQ: begin
            if (math_sts.done) begin
               msq_in         = math_sts.result[SQ_W-1:0];
               math_cmd.start = 1'b1;
               math_cmd.op    = MATH_MUL;
               math_cmd.a     = OPND_W'(mean_ff);
               math_cmd.b     = mean_ff;
               state_in       = ST_RD_SQR;
            end
         end

         ST_RD_SQR: begin
            // square of the mean wraps at 64 bits; negative variance reads as 0
            if (math_sts.done) begin
               var_in         = (msq_ext > math_sts.result) ?
                                SQ_W'(msq_ext - math_sts.result) : '0;
               math_cmd.start = 1'b1;
               math_cmd.op    = MATH_SQRT;
               math_cmd.a     = (msq_ext > math_sts.result) ?
                                OPND_W'(msq_ext - math_sts.result) : '0;
               state_in       = ST_RD_SIG;
            end
         end

         ST_RD_SIG: begin
            if (math_sts.done) begin
               sig_in         = math_sts.result[OUT_W-1:0];
               math_cmd.start = 1'b1;
               math_cmd.op    = MATH_DIV;
               math_cmd.a     = var_ff;
               math_cmd.b     = MEAN_W'(set_count_ff);
               state_in       = ST_RD_VDIV;
            end
         end

         ST_RD_VDIV: begin
            if (math_sts.done) begin
               math_cmd.start = 1'b1;
               math_cmd.op    = MATH_SQRT;
               math_cmd.a     = math_sts.result[OPND_W-1:0];
               state_in       = ST_RD_ERR;
            end
         end

         ST_RD_ERR: begin
            if (math_sts.done) begin
               err_in   = math_sts.result[OUT_W-1:0];
               has_in   = 1'b1;
               state_in = ST_RD_DONE;
            end
         end

         ST_RD_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.mean       = mean_ff[OUT_W-1:0];
               rsp_in.sigma      = sig_ff;
               rsp_in.mean_error = err_ff;
               rsp_in.has_data   = has_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         pos0_ff         <= '0;
         pos1_ff         <= '0;
         pos2_ff         <= '0;
         pos3_ff         <= '0;
         lane_ff         <= '0;
         site_ff         <= '0;
         sample_count_ff <= '0;
         set_count_ff    <= '0;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos0_ff         <= pos0_in;
         pos1_ff         <= pos1_in;
         pos2_ff         <= pos2_in;
         pos3_ff         <= pos3_in;
         lane_ff         <= lane_in;
         site_ff         <= site_in;
         sample_count_ff <= sample_count_in;
         set_count_ff    <= set_count_in;
         clr_ff          <= clr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      addr_ff <= addr_in;
      sq_ff   <= sq_in;
      zero_ff <= zero_in;
      mean_ff <= mean_in;
      msq_ff  <= msq_in;
      var_ff  <= var_in;
      sig_ff  <= sig_in;
      err_ff  <= err_in;
      has_ff  <= has_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_store_write_ctx: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_ACC_MAG))
      else $error("store written outside clear or accumulate");

   a_unit_done_ctx: assert property (@(posedge clock) disable iff (reset)
      math_sts.done |-> !(state_ff == ST_IDLE || state_ff == ST_CLEAR ||
                          state_ff == ST_RD_FETCH || state_ff == ST_RD_DONE))
      else $error("arithmetic unit finished with no consumer");

   a_counts_move_together: assert property (@(posedge clock) disable iff (reset)
      !$stable(set_count_ff) |-> !$stable(sample_count_ff))
      else $error("set count moved without sample count");

   a_no_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.has_data) |->
      (rsp_ff.mean == '0 && rsp_ff.sigma == '0 && rsp_ff.mean_error == '0))
      else $error("statistics reported without data");
`endif

endmodule

FILE: rtl/lsms_store.sv
// Per-site sum and square-sum memory, one write and one registered read port.
module lsms_store
   import lsms_pkg::*;
#(
   parameter int Depth = MAX_SITES_DEF,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AddrW-1:0] waddr,
   input  site_word_type wdata,
   input  logic          re,
   input  logic [AddrW-1:0] raddr,
   output site_word_type rdata
);

   site_word_type mem [Depth];
   site_word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/lsms_math.sv
// Shared iterative unit: restoring divide, digit-by-digit square root, shift-add multiply.
module lsms_math
   import lsms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  math_cmd_type cmd,
   output math_sts_type sts
);

   math_op_type       op_ff, op_in;
   logic [OPND_W-1:0] shreg_ff, shreg_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [DIVR_W-1:0] divr_ff, divr_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVR_W:0]   div_trial;
   logic [REM_W-1:0]  sq_trial;
   logic [REM_W-1:0]  sq_try;
   logic [STEP_W-1:0] last_step;

   always_comb begin
      op_in     = op_ff;
      shreg_in  = shreg_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      divr_in   = divr_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      div_trial = {rem_ff[DIVR_W-1:0], shreg_ff[OPND_W-1]};
      sq_trial  = {rem_ff[REM_W-3:0], shreg_ff[OPND_W-1 -: 2]};
      sq_try    = REM_W'({root_ff, 2'b01});
      case (op_ff)
         MATH_DIV:  last_step = STEP_W'(DIV_STEPS - 1);
         MATH_SQRT: last_step = STEP_W'(SQRT_STEPS - 1);
         MATH_MUL:  last_step = STEP_W'(MUL_STEPS - 1);
         default:   last_step = '0;
      endcase

      if (cmd.start) begin
         op_in    = cmd.op;
         shreg_in = cmd.a;
         rem_in   = '0;
         root_in  = '0;
         acc_in   = '0;
         mcand_in = PROD_W'(cmd.b);
         divr_in  = cmd.b[DIVR_W-1:0];
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (op_ff)
            MATH_DIV: begin
               if (div_trial >= {1'b0, divr_ff}) begin
                  rem_in   = REM_W'(div_trial - {1'b0, divr_ff});
                  shreg_in = {shreg_ff[OPND_W-2:0], 1'b1};
               end else begin
                  rem_in   = REM_W'(div_trial);
                  shreg_in = {shreg_ff[OPND_W-2:0], 1'b0};
               end
            end
            MATH_SQRT: begin
               shreg_in = {shreg_ff[OPND_W-3:0], 2'b00};
               if (sq_trial >= sq_try) begin
                  rem_in  = sq_trial - sq_try;
                  root_in = {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_in  = sq_trial;
                  root_in = {root_ff[ROOT_W-2:0], 1'b0};
               end
            end
            MATH_MUL: begin
               if (shreg_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               shreg_in = shreg_ff >> 1;
               mcand_in = mcand_ff << 1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= MATH_DIV;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         op_ff   <= op_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      divr_ff  <= divr_in;
   end

   always_comb begin
      sts.done = done_ff;
      case (op_ff)
         MATH_DIV:  sts.result = PROD_W'(shreg_ff);
         MATH_SQRT: sts.result = PROD_W'(root_ff);
         MATH_MUL:  sts.result = acc_ff;
         default:   sts.result = '0;
      endcase
   end

endmodule
